### rtl/core/mwrl_pkg.sv
// Shared types and constants for the multi-window rate limiter.
// No dependencies; every other file refers to this package by scoped names.

package mwrl_pkg;

  localparam int NWIN        = 3;
  localparam int LEN_W       = 37;
  localparam int CAP_W       = 16;
  localparam int TIME_BITS_D = 48;
  localparam int COUNT_BITS_D = 16;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 6;
  localparam int OUT_DATA_W  = ((LEN_W + 7) / 8) * 8;

  localparam logic [LEN_W-1:0] SHORT_LEN_RST = LEN_W'(64'd60000000);
  localparam logic [LEN_W-1:0] MID_LEN_RST   = LEN_W'(64'd3600000000);
  localparam logic [LEN_W-1:0] LONG_LEN_RST  = LEN_W'(64'd86400000000);
  localparam logic [CAP_W-1:0] SHORT_CAP_RST = CAP_W'(540);
  localparam logic [CAP_W-1:0] MID_CAP_RST   = CAP_W'(4500);
  localparam logic [CAP_W-1:0] LONG_CAP_RST  = CAP_W'(9000);

  typedef enum logic [2:0] {
    REG_SHORT_LEN,
    REG_MID_LEN,
    REG_LONG_LEN,
    REG_SHORT_CAP,
    REG_MID_CAP,
    REG_LONG_CAP
  } mwrl_reg_t;

  // Window settings; entry 0 is the short window, entry 2 the long one.
  typedef struct packed {
    logic [NWIN-1:0][LEN_W-1:0] len;
    logic [NWIN-1:0][CAP_W-1:0] cap;
  } mwrl_cfg_t;

  // Partial result handed from cell to cell.
  typedef struct packed {
    logic             vld;
    logic             deny;
    logic [LEN_W-1:0] wait_us;
  } mwrl_link_t;

endpackage

### rtl/core/multi_window_rate_limiter.sv
// Top level of the multi-window rate limiter: configuration registers, a row
// of three window cells and an output register with a skid stage.
// Depends on mwrl_pkg, mwrl_cfg and mwrl_cell.
//
//   channel  direction  handshake                    payload
//   in_      slave      in_tvalid / in_tready        tdata: now_us
//   out_     master     out_tvalid / out_tready      tdata: wait_us, tuser: granted
//   cfg_     APB slave  psel, penable, pready        paddr, pwdata, prdata
//
// One request per cycle is taken while in_tready is high; the grant decision
// and the window updates happen in the cycle of acceptance, and the result
// then passes the entry register, one register per cell and the output
// register. Reset clears all windows and loads the default lengths and caps.
// A stalled output fills the skid stage, after which in_tready drops until
// the held result is taken.

module multi_window_rate_limiter #(
  parameter int TIME_BITS  = mwrl_pkg::TIME_BITS_D,
  parameter int COUNT_BITS = mwrl_pkg::COUNT_BITS_D,
  localparam int IN_DATA_W = ((TIME_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [IN_DATA_W-1:0]              in_tdata,   // now_us
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mwrl_pkg::OUT_DATA_W-1:0]   out_tdata,  // wait_us
  output logic                              out_tuser,  // granted
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [mwrl_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [mwrl_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [mwrl_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  mwrl_pkg::mwrl_cfg_t            cfg;
  logic [TIME_BITS-1:0]           now;
  logic                           adv;
  logic                           acc;
  logic                           grant;
  logic [mwrl_pkg::NWIN:0]        sat_c;
  mwrl_pkg::mwrl_link_t           lnk [mwrl_pkg::NWIN+1];
  mwrl_pkg::mwrl_link_t           s1_r, s1_nxt;
  mwrl_pkg::mwrl_link_t           fin;
  logic                           take;
  logic                           out_fire;
  logic                           out_vld_r;
  logic                           skid_vld_r;
  mwrl_pkg::mwrl_link_t           out_r, skid_r;

  assign cfg_pready = 1'b1;

  mwrl_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  assign now       = in_tdata[TIME_BITS-1:0];
  assign adv       = !skid_vld_r;
  assign in_tready = adv;
  assign acc       = in_tvalid && in_tready;

  // Saturation ripples along the row; any saturated window denies the call.
  assign sat_c[0] = 1'b0;
  assign grant    = acc && !sat_c[mwrl_pkg::NWIN];

  always_comb begin
    s1_nxt.vld     = acc;
    s1_nxt.deny    = sat_c[mwrl_pkg::NWIN];
    s1_nxt.wait_us = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
    end else if (adv) begin
      s1_r <= s1_nxt;
    end
  end

  assign lnk[0] = s1_r;

  for (genvar g = 0; g < mwrl_pkg::NWIN; g++) begin : g_cell
    mwrl_cell #(
      .TIME_BITS  (TIME_BITS),
      .COUNT_BITS (COUNT_BITS),
      .IDX        (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .acc     (acc),
      .now     (now),
      .len     (cfg.len[g]),
      .cap     (cfg.cap[g]),
      .sat_in  (sat_c[g]),
      .sat_out (sat_c[g+1]),
      .grant   (grant),
      .lnk_in  (lnk[g]),
      .lnk_out (lnk[g+1])
    );
  end

  assign fin      = lnk[mwrl_pkg::NWIN];
  assign take     = adv && fin.vld;
  assign out_fire = out_vld_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_fire) begin
        out_r      <= skid_r;
        skid_vld_r <= 1'b0;
      end
    end else if (take) begin
      if (!out_vld_r || out_fire) begin
        out_r     <= fin;
        out_vld_r <= 1'b1;
      end else begin
        skid_r     <= fin;
        skid_vld_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = !out_r.deny;
  assign out_tdata  = mwrl_pkg::OUT_DATA_W'(out_r.wait_us);

endmodule

### rtl/core/mwrl_cfg.sv
// Configuration register file with an APB-style write and read port.
// Depends on mwrl_pkg for register codes, widths and reset values.

module mwrl_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mwrl_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [mwrl_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [mwrl_pkg::CFG_DATA_W-1:0]     prdata,
  output mwrl_pkg::mwrl_cfg_t                 cfg
);

  mwrl_pkg::mwrl_cfg_t cfg_r, cfg_nxt;
  mwrl_pkg::mwrl_reg_t idx;
  logic                wr_en;

  // Registers sit on 8-byte boundaries; the low address bits are ignored.
  assign idx   = mwrl_pkg::mwrl_reg_t'(paddr[mwrl_pkg::CFG_ADDR_W-1:3]);
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        mwrl_pkg::REG_SHORT_LEN: cfg_nxt.len[0] = pwdata[mwrl_pkg::LEN_W-1:0];
        mwrl_pkg::REG_MID_LEN:   cfg_nxt.len[1] = pwdata[mwrl_pkg::LEN_W-1:0];
        mwrl_pkg::REG_LONG_LEN:  cfg_nxt.len[2] = pwdata[mwrl_pkg::LEN_W-1:0];
        mwrl_pkg::REG_SHORT_CAP: cfg_nxt.cap[0] = pwdata[mwrl_pkg::CAP_W-1:0];
        mwrl_pkg::REG_MID_CAP:   cfg_nxt.cap[1] = pwdata[mwrl_pkg::CAP_W-1:0];
        mwrl_pkg::REG_LONG_CAP:  cfg_nxt.cap[2] = pwdata[mwrl_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.len[0] <= mwrl_pkg::SHORT_LEN_RST;
      cfg_r.len[1] <= mwrl_pkg::MID_LEN_RST;
      cfg_r.len[2] <= mwrl_pkg::LONG_LEN_RST;
      cfg_r.cap[0] <= mwrl_pkg::SHORT_CAP_RST;
      cfg_r.cap[1] <= mwrl_pkg::MID_CAP_RST;
      cfg_r.cap[2] <= mwrl_pkg::LONG_CAP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      mwrl_pkg::REG_SHORT_LEN: prdata = mwrl_pkg::CFG_DATA_W'(cfg_r.len[0]);
      mwrl_pkg::REG_MID_LEN:   prdata = mwrl_pkg::CFG_DATA_W'(cfg_r.len[1]);
      mwrl_pkg::REG_LONG_LEN:  prdata = mwrl_pkg::CFG_DATA_W'(cfg_r.len[2]);
      mwrl_pkg::REG_SHORT_CAP: prdata = mwrl_pkg::CFG_DATA_W'(cfg_r.cap[0]);
      mwrl_pkg::REG_MID_CAP:   prdata = mwrl_pkg::CFG_DATA_W'(cfg_r.cap[1]);
      mwrl_pkg::REG_LONG_CAP:  prdata = mwrl_pkg::CFG_DATA_W'(cfg_r.cap[2]);
      default:                 prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/mwrl_cell.sv
// One window cell: holds a window's start time and call count, decides
// restart and saturation, and folds its remaining time into the passing link.
// Depends on mwrl_pkg for the link type and field widths.

module mwrl_cell #(
  parameter int TIME_BITS  = mwrl_pkg::TIME_BITS_D,
  parameter int COUNT_BITS = mwrl_pkg::COUNT_BITS_D,
  parameter int IDX        = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       acc,
  input  logic [TIME_BITS-1:0]       now,
  input  logic [mwrl_pkg::LEN_W-1:0] len,
  input  logic [mwrl_pkg::CAP_W-1:0] cap,
  input  logic                       sat_in,
  output logic                       sat_out,
  input  logic                       grant,
  input  mwrl_pkg::mwrl_link_t       lnk_in,
  output mwrl_pkg::mwrl_link_t       lnk_out
);

  localparam int CMPW = (COUNT_BITS > mwrl_pkg::CAP_W) ? COUNT_BITS : mwrl_pkg::CAP_W;

  logic [TIME_BITS-1:0]       start_r, start_nxt;
  logic [COUNT_BITS-1:0]      count_r, count_nxt;
  logic [TIME_BITS-1:0]       elapsed;
  logic                       restart;
  logic [TIME_BITS-1:0]       el_eff;
  logic [COUNT_BITS-1:0]      cnt_eff;
  logic                       sat;
  logic [mwrl_pkg::LEN_W-1:0] rem;
  logic [mwrl_pkg::LEN_W-1:0] rem_line_r [IDX+1];
  logic [mwrl_pkg::LEN_W-1:0] rem_d;
  mwrl_pkg::mwrl_link_t       lnk_r, lnk_nxt;

  assign elapsed = now - start_r;
  assign restart = elapsed >= TIME_BITS'(len);
  assign el_eff  = restart ? '0 : elapsed;
  assign cnt_eff = restart ? '0 : count_r;
  assign sat     = (CMPW'(cnt_eff) >= CMPW'(cap)) || (cnt_eff == '1);
  assign sat_out = sat_in || sat;

  // Without a restart the elapsed time is below the length, so it fits LEN_W.
  assign rem = len - el_eff[mwrl_pkg::LEN_W-1:0];

  assign start_nxt = restart ? now : start_r;
  assign count_nxt = grant ? cnt_eff + COUNT_BITS'(1) : cnt_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      count_r <= '0;
    end else if (acc) begin
      start_r <= start_nxt;
      count_r <= count_nxt;
    end
  end

  // The remaining time waits here until the beat's link reaches this cell.
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_line_r[0] <= sat ? rem : '0;
      for (int k = 1; k <= IDX; k++) begin
        rem_line_r[k] <= rem_line_r[k-1];
      end
    end
  end

  assign rem_d = rem_line_r[IDX];

  always_comb begin
    lnk_nxt         = lnk_in;
    lnk_nxt.wait_us = (rem_d > lnk_in.wait_us) ? rem_d : lnk_in.wait_us;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lnk_r.vld <= 1'b0;
    end else if (adv) begin
      lnk_r <= lnk_nxt;
    end
  end

  assign lnk_out = lnk_r;

endmodule
